// ===== rtl/core/pidaw_pkg.sv =====
// Shared types and constants for the PID controller with anti-windup.
package pidaw_pkg;

  localparam int unsigned DEFAULT_SCALE = 1000;
  localparam longint     MAX_INTEGRAL  = 64'sd1000000000;
  localparam int unsigned MS_PER_S      = 1000;

  localparam int unsigned MUL_AW = 66;
  localparam int unsigned MUL_BW = 32;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned DIV_NW = 82;
  localparam int unsigned DIV_DW = 32;
  localparam int unsigned SUM_W  = DIV_NW + 2;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_RESET  = 2'd1,
    MODE_LOAD   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_GAIN_SCALE = 3'd3,
    CFG_DEAD_ZONE  = 3'd4,
    CFG_DRIVE_MIN  = 3'd5,
    CFG_DRIVE_MAX  = 3'd6,
    CFG_OPTIONS    = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_DZ, S_CHG, S_PM, S_PD, S_IM1, S_IM2, S_ID, S_IADD,
    S_ICLAMP, S_AD, S_DM1, S_DM2, S_DD, S_OUT, S_LD1, S_LD2, S_UN, S_RES
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/core/pidaw_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module pidaw_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pidaw_pkg::MUL_AW-1:0]     a_i,
  input  logic [pidaw_pkg::MUL_BW-1:0]     b_i,
  output pidaw_pkg::unit_stat_t            stat_o,
  output logic [pidaw_pkg::MUL_PW-1:0]     prod_o
);

  localparam int unsigned CW = $clog2(pidaw_pkg::MUL_BW);

  logic [pidaw_pkg::MUL_PW-1:0] acc_q;
  logic [pidaw_pkg::MUL_AW-1:0] a_q;
  logic [CW-1:0]                cnt_q;
  logic                         busy_q, done_q;
  logic [pidaw_pkg::MUL_AW:0]   t;

  assign t = {1'b0, acc_q[pidaw_pkg::MUL_PW-1:pidaw_pkg::MUL_BW]} +
             (acc_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(pidaw_pkg::MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{pidaw_pkg::MUL_AW{1'b0}}, b_i};
      a_q   <= a_i;
    end else if (busy_q) begin
      acc_q <= {t, acc_q[pidaw_pkg::MUL_BW-1:1]};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = acc_q;

endmodule

// ===== rtl/core/pidaw_div.sv =====
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module pidaw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pidaw_pkg::DIV_NW-1:0]  num_i,
  input  logic [pidaw_pkg::DIV_DW-1:0]  den_i,
  output pidaw_pkg::unit_stat_t         stat_o,
  output logic [pidaw_pkg::DIV_NW-1:0]  quo_o
);

  localparam int unsigned CW = $clog2(pidaw_pkg::DIV_NW);

  logic [pidaw_pkg::DIV_NW-1:0] quo_q;
  logic [pidaw_pkg::DIV_DW-1:0] rem_q, den_q;
  logic [CW-1:0]                cnt_q;
  logic                         busy_q, done_q;
  logic [pidaw_pkg::DIV_DW:0]   t, diff;
  logic                         ge;

  assign t    = {rem_q, quo_q[pidaw_pkg::DIV_NW-1]};
  assign ge   = t >= {1'b0, den_q};
  assign diff = t - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(pidaw_pkg::DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[pidaw_pkg::DIV_NW-2:0], ge};
      rem_q <= ge ? diff[pidaw_pkg::DIV_DW-1:0] : t[pidaw_pkg::DIV_DW-1:0];
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/pid_controller_antiwindup.sv =====
// Integer PID controller top level: registers, sequencer and datapath.
// Update item with nonzero elapsed_ms: five multiply steps and five divide steps on the shared
// bit-serial units, plus seven single steps; with zero elapsed_ms it runs like a hold item.
// Reset and hold items run one divide for the integral; load items run two load steps first.
// One item at a time; the next is taken once the result sits in the output register.
// rst_ni clears state, configuration and controller registers; option bit 0 resets to 1, bit 1 to 0.
module pid_controller_antiwindup (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [111:0] s_axis_tdata_i,  // target, measured, elapsed_ms, integral_value
  input  logic [1:0]   s_axis_tuser_i,  // mode
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,  // drive, integral_units
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned AW = pidaw_pkg::MUL_AW;
  localparam int unsigned BW = pidaw_pkg::MUL_BW;
  localparam int unsigned PW = pidaw_pkg::MUL_PW;
  localparam int unsigned NW = pidaw_pkg::DIV_NW;
  localparam int unsigned DW = pidaw_pkg::DIV_DW;
  localparam int unsigned SW = pidaw_pkg::SUM_W;

  function automatic logic signed [63:0] clamp64(logic signed [63:0] v,
                                                 logic signed [63:0] lo,
                                                 logic signed [63:0] hi);
    logic signed [63:0] r;
    if (v < lo)      r = lo;
    else if (v > hi) r = hi;
    else             r = v;
    return r;
  endfunction

  function automatic logic signed [SW-1:0] signed_q(logic neg, logic [NW-1:0] q);
    logic signed [SW-1:0] e;
    e = $signed({2'b00, q});
    return neg ? -e : e;
  endfunction

  // configuration
  logic signed [31:0] gp_q, gi_q, gd_q, dmin_q, dmax_q;
  logic [15:0]        gscale_q;
  logic [30:0]        dz_q;
  logic [1:0]         opt_q;

  // controller state
  logic signed [63:0] acc_q;
  logic signed [32:0] lerr_q;
  logic signed [31:0] lmeas_q, ltgt_q, held_q;
  logic               seeded_q;

  // per item work
  logic signed [31:0] tgt_q, meas_q, iv_q;
  logic [15:0]        dt_q, scale_q;
  logic signed [32:0] err_q;
  logic signed [33:0] chg_q;
  logic signed [63:0] lim_lo_q, lim_hi_q, inc_q;
  logic signed [64:0] incsum_q;
  logic [31:0]        sk_q, sd_q;
  logic signed [SW-1:0] sum_q;
  logic [31:0]        units_q;
  logic [63:0]        out_data_q;
  logic               out_valid_q;

  pidaw_pkg::state_e state_q, state_d;
  logic              go_q;
  logic              accept;

  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [NW-1:0] div_n, quo;
  logic [DW-1:0] div_d;
  logic          mul_st, div_st;
  pidaw_pkg::unit_stat_t mul_stat, div_stat;

  logic [32:0] err_mag;
  logic [33:0] chg_mag;
  logic [31:0] gp_mag, gi_mag, gd_mag;
  logic [63:0] acc_mag;
  logic        p_neg, i_neg, d_neg;
  logic signed [33:0] dzs;
  logic signed [32:0] lerr_eff;
  logic signed [31:0] lmeas_eff;
  logic signed [63:0] acc_sat;
  logic               is_mul, is_div;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == pidaw_pkg::S_IDLE);

  assign err_mag = err_q[32] ? 33'(-err_q) : 33'(err_q);
  assign chg_mag = chg_q[33] ? 34'(-chg_q) : 34'(chg_q);
  assign gp_mag  = gp_q[31] ? 32'(-gp_q) : 32'(gp_q);
  assign gi_mag  = gi_q[31] ? 32'(-gi_q) : 32'(gi_q);
  assign gd_mag  = gd_q[31] ? 32'(-gd_q) : 32'(gd_q);
  assign acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign p_neg   = gp_q[31] ^ err_q[32];
  assign i_neg   = gi_q[31] ^ err_q[32];
  assign d_neg   = opt_q[0] ? ~(gd_q[31] ^ chg_q[33]) : (gd_q[31] ^ chg_q[33]);
  assign dzs     = $signed({3'b000, dz_q});
  assign lerr_eff  = seeded_q ? lerr_q : err_q;
  assign lmeas_eff = seeded_q ? lmeas_q : meas_q;
  assign acc_sat = (incsum_q[64] != incsum_q[63]) ?
                   (incsum_q[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) :
                   incsum_q[63:0];

  assign is_mul = (state_q == pidaw_pkg::S_PM) || (state_q == pidaw_pkg::S_IM1) ||
                  (state_q == pidaw_pkg::S_IM2) || (state_q == pidaw_pkg::S_DM1) ||
                  (state_q == pidaw_pkg::S_DM2);
  assign is_div = (state_q == pidaw_pkg::S_PD) || (state_q == pidaw_pkg::S_ID) ||
                  (state_q == pidaw_pkg::S_AD) || (state_q == pidaw_pkg::S_DD) ||
                  (state_q == pidaw_pkg::S_UN);
  assign mul_st = go_q && is_mul;
  assign div_st = go_q && is_div;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = DW'(scale_q);
    unique case (state_q)
      pidaw_pkg::S_PM: begin
        mul_a = AW'(err_mag);
        mul_b = gp_mag;
      end
      pidaw_pkg::S_IM1: begin
        mul_a = AW'(err_mag);
        mul_b = gi_mag;
      end
      pidaw_pkg::S_IM2: begin
        mul_a = prod[AW-1:0];
        mul_b = BW'(dt_q);
      end
      pidaw_pkg::S_DM1: begin
        mul_a = AW'(chg_mag);
        mul_b = gd_mag;
      end
      pidaw_pkg::S_DM2: begin
        mul_a = prod[AW-1:0];
        mul_b = BW'(pidaw_pkg::MS_PER_S);
      end
      pidaw_pkg::S_PD: div_n = prod[NW-1:0];
      pidaw_pkg::S_ID: begin
        div_n = prod[NW-1:0];
        div_d = sk_q;
      end
      pidaw_pkg::S_DD: begin
        div_n = prod[NW-1:0];
        div_d = sd_q;
      end
      pidaw_pkg::S_AD, pidaw_pkg::S_UN: div_n = NW'(acc_mag);
      default: ;
    endcase
  end

  pidaw_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_st),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  pidaw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_st),
    .num_i  (div_n),
    .den_i  (div_d),
    .stat_o (div_stat),
    .quo_o  (quo)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidaw_pkg::S_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= (state_d != state_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidaw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (pidaw_pkg::mode_e'(s_axis_tuser_i))
            pidaw_pkg::MODE_UPDATE:
              state_d = (s_axis_tdata_i[79:64] != 16'd0) ? pidaw_pkg::S_ERR
                                                          : pidaw_pkg::S_UN;
            pidaw_pkg::MODE_LOAD: state_d = pidaw_pkg::S_LD1;
            default:              state_d = pidaw_pkg::S_UN;
          endcase
        end
      end
      pidaw_pkg::S_ERR:    state_d = pidaw_pkg::S_DZ;
      pidaw_pkg::S_DZ:     state_d = pidaw_pkg::S_CHG;
      pidaw_pkg::S_CHG:    state_d = pidaw_pkg::S_PM;
      pidaw_pkg::S_PM:     if (mul_stat.done) state_d = pidaw_pkg::S_PD;
      pidaw_pkg::S_PD:     if (div_stat.done) state_d = pidaw_pkg::S_IM1;
      pidaw_pkg::S_IM1:    if (mul_stat.done) state_d = pidaw_pkg::S_IM2;
      pidaw_pkg::S_IM2:    if (mul_stat.done) state_d = pidaw_pkg::S_ID;
      pidaw_pkg::S_ID:     if (div_stat.done) state_d = pidaw_pkg::S_IADD;
      pidaw_pkg::S_IADD:   state_d = pidaw_pkg::S_ICLAMP;
      pidaw_pkg::S_ICLAMP: state_d = pidaw_pkg::S_AD;
      pidaw_pkg::S_AD:     if (div_stat.done) state_d = pidaw_pkg::S_DM1;
      pidaw_pkg::S_DM1:    if (mul_stat.done) state_d = pidaw_pkg::S_DM2;
      pidaw_pkg::S_DM2:    if (mul_stat.done) state_d = pidaw_pkg::S_DD;
      pidaw_pkg::S_DD:     if (div_stat.done) state_d = pidaw_pkg::S_OUT;
      pidaw_pkg::S_OUT:    state_d = pidaw_pkg::S_UN;
      pidaw_pkg::S_LD1:    state_d = pidaw_pkg::S_LD2;
      pidaw_pkg::S_LD2:    state_d = pidaw_pkg::S_UN;
      pidaw_pkg::S_UN:     if (div_stat.done) state_d = pidaw_pkg::S_RES;
      pidaw_pkg::S_RES:
        if (!out_valid_q || m_axis_tready_i) state_d = pidaw_pkg::S_IDLE;
      default:             state_d = pidaw_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q     <= '0;
      gi_q     <= '0;
      gd_q     <= '0;
      gscale_q <= '0;
      dz_q     <= '0;
      dmin_q   <= '0;
      dmax_q   <= '0;
      opt_q    <= 2'b01;
    end else if (cfg_we_i) begin
      unique case (pidaw_pkg::cfg_idx_e'(cfg_idx_i))
        pidaw_pkg::CFG_GAIN_P:     gp_q     <= cfg_data_i;
        pidaw_pkg::CFG_GAIN_I:     gi_q     <= cfg_data_i;
        pidaw_pkg::CFG_GAIN_D:     gd_q     <= cfg_data_i;
        pidaw_pkg::CFG_GAIN_SCALE: gscale_q <= cfg_data_i[15:0];
        pidaw_pkg::CFG_DEAD_ZONE:  dz_q     <= cfg_data_i[30:0];
        pidaw_pkg::CFG_DRIVE_MIN:  dmin_q   <= cfg_data_i;
        pidaw_pkg::CFG_DRIVE_MAX:  dmax_q   <= cfg_data_i;
        pidaw_pkg::CFG_OPTIONS:    opt_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      lerr_q      <= '0;
      lmeas_q     <= '0;
      ltgt_q      <= '0;
      held_q      <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == pidaw_pkg::S_RES) && (!out_valid_q || m_axis_tready_i))
        out_valid_q <= 1'b1;
      else if (m_axis_tready_i)
        out_valid_q <= 1'b0;
      unique case (state_q)
        pidaw_pkg::S_IDLE:
          if (accept && (pidaw_pkg::mode_e'(s_axis_tuser_i) == pidaw_pkg::MODE_RESET)) begin
            acc_q    <= '0;
            lerr_q   <= '0;
            lmeas_q  <= '0;
            held_q   <= '0;
            seeded_q <= 1'b0;
          end
        pidaw_pkg::S_ERR: begin
          if (opt_q[1] && seeded_q && (tgt_q != ltgt_q)) acc_q <= '0;
          ltgt_q <= tgt_q;
        end
        pidaw_pkg::S_CHG: begin
          lerr_q   <= err_q;
          lmeas_q  <= meas_q;
          seeded_q <= 1'b1;
        end
        pidaw_pkg::S_ICLAMP: acc_q <= clamp64(acc_sat, lim_lo_q, lim_hi_q);
        pidaw_pkg::S_OUT: begin
          if (sum_q < $signed(dmin_q))      held_q <= dmin_q;
          else if (sum_q > $signed(dmax_q)) held_q <= dmax_q;
          else                              held_q <= sum_q[31:0];
        end
        pidaw_pkg::S_LD1:
          acc_q <= 64'(iv_q) * 64'(scale_q);
        pidaw_pkg::S_LD2:
          if ((dmin_q != 0) || (dmax_q != 0)) acc_q <= clamp64(acc_q, lim_lo_q, lim_hi_q);
        default: ;
      endcase
    end
  end

  // datapath work registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pidaw_pkg::S_IDLE:
        if (accept) begin
          tgt_q   <= s_axis_tdata_i[31:0];
          meas_q  <= s_axis_tdata_i[63:32];
          dt_q    <= s_axis_tdata_i[79:64];
          iv_q    <= s_axis_tdata_i[111:80];
          scale_q <= (gscale_q != 16'd0) ? gscale_q : 16'(pidaw_pkg::DEFAULT_SCALE);
        end
      pidaw_pkg::S_ERR:
        err_q <= $signed({tgt_q[31], tgt_q}) - $signed({meas_q[31], meas_q});
      pidaw_pkg::S_DZ:
        if (dz_q != 31'd0) begin
          if (err_q > 0) err_q <= (err_q <= dzs) ? '0 : 33'(err_q - dzs);
          else           err_q <= (err_q >= -dzs) ? '0 : 33'(err_q + dzs);
        end
      pidaw_pkg::S_CHG: begin
        if (opt_q[0]) chg_q <= $signed({{2{meas_q[31]}}, meas_q}) -
                               $signed({{2{lmeas_eff[31]}}, lmeas_eff});
        else          chg_q <= $signed({err_q[32], err_q}) -
                               $signed({lerr_eff[32], lerr_eff});
        if ((dmin_q == 0) && (dmax_q == 0)) begin
          lim_lo_q <= -pidaw_pkg::MAX_INTEGRAL;
          lim_hi_q <= pidaw_pkg::MAX_INTEGRAL;
        end else begin
          lim_lo_q <= 64'(dmin_q) * 64'(scale_q);
          lim_hi_q <= 64'(dmax_q) * 64'(scale_q);
        end
        sk_q <= 32'(scale_q) * 32'(pidaw_pkg::MS_PER_S);
        sd_q <= 32'(scale_q) * 32'(dt_q);
      end
      pidaw_pkg::S_PD: if (div_stat.done) sum_q <= signed_q(p_neg, quo);
      pidaw_pkg::S_ID:
        if (div_stat.done) begin
          if (!i_neg) inc_q <= ((|quo[NW-1:64]) || quo[63]) ? {1'b0, {63{1'b1}}}
                                                             : $signed(quo[63:0]);
          else inc_q <= ((|quo[NW-1:64]) || (quo[63] && (|quo[62:0]))) ? {1'b1, 63'd0}
                                                                         : -$signed(quo[63:0]);
        end
      pidaw_pkg::S_IADD: incsum_q <= $signed({acc_q[63], acc_q}) + $signed({inc_q[63], inc_q});
      pidaw_pkg::S_AD: if (div_stat.done) sum_q <= sum_q + signed_q(acc_q[63], quo);
      pidaw_pkg::S_DD: if (div_stat.done) sum_q <= sum_q + signed_q(d_neg, quo);
      pidaw_pkg::S_LD1: begin
        lim_lo_q <= 64'(dmin_q) * 64'(scale_q);
        lim_hi_q <= 64'(dmax_q) * 64'(scale_q);
      end
      pidaw_pkg::S_UN:
        if (div_stat.done) begin
          if (!acc_q[63]) units_q <= (|quo[NW-1:31]) ? 32'h7FFF_FFFF : quo[31:0];
          else units_q <= ((|quo[NW-1:32]) || (quo[31] && (|quo[30:0]))) ? 32'h8000_0000
                                                                          : 32'(-quo[31:0]);
        end
      pidaw_pkg::S_RES:
        if (!out_valid_q || m_axis_tready_i) out_data_q <= {units_q, held_q};
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_mul_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> is_mul) else $error("multiplier finished outside a multiply step");
  a_div_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> is_div) else $error("divider finished outside a divide step");
  a_units_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_st |-> !mul_stat.busy) and (div_st |-> !div_stat.busy))
    else $error("unit started while busy");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o) else $error("sequencer stayed idle after a transfer");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result lost");

endmodule
